/* hw/rtl/rsmf_pkg.sv */
// ----------------------------------------------------------------------------
// rsmf_pkg
// Shared types and constants for the range sample median filter.
// ----------------------------------------------------------------------------
package rsmf_pkg;

    localparam int MAX_SAMPLES  = 32;
    localparam int ADDR_W       = $clog2(MAX_SAMPLES);
    localparam int COUNT_W      = $clog2(MAX_SAMPLES + 1);
    localparam int RAW_W        = 16;
    localparam int MM_W         = 11;
    localparam int CFG_W        = 6;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RAW_W-1:0] RANGE_MIN_MM       = RAW_W'(10);
    localparam logic [RAW_W-1:0] RANGE_MAX_MM       = RAW_W'(1200);
    localparam logic [CFG_W-1:0] SAMPLE_COUNT_RESET = CFG_W'(16);

    typedef struct packed {
        logic [RAW_W-1:0] raw_range;
        logic             abort;
    } in_item_t;

    typedef struct packed {
        logic [MM_W-1:0] median_mm;
        logic            found;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_DROP  = 2'd0,
        CMD_KEEP  = 2'd1,
        CMD_ABORT = 2'd2
    } cmd_kind_t;

    // Classified item passed from the front end to the sorter
    typedef struct packed {
        cmd_kind_t       kind;
        logic [MM_W-1:0] value;
        logic            last;
    } cmd_t;

endpackage

/* hw/rtl/range_sample_median_filter.sv */
// ----------------------------------------------------------------------------
// range_sample_median_filter
// Range-gated batch median filter for raw range readings.
// ----------------------------------------------------------------------------
//  port       | dir | payload           | moves on
//  in_*       | in  | raw_range, abort  | in_valid high, in_stall low
//  out_*      | out | median_mm, found  | out_valid high, out_stall low
//  cfg_*      | in  | sample_count      | cfg_we high
//
//  A kept reading is inserted by the sorter, which compares it with the
//  stored readings above it one by one, moving each up a place in the
//  sorter's single-write store, then writes it into the gap. A batch end
//  reads the median out of the store and loads it into the output register.
//  A 4-entry queue lets input run ahead.
//  Reset empties the batch and sets sample_count to 16; the store itself
//  is not cleared. Input stalls only while the queue is full.
// ----------------------------------------------------------------------------
module range_sample_median_filter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  rsmf_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output rsmf_pkg::out_item_t         out_data,
    input  logic                        cfg_we,
    input  logic [rsmf_pkg::CFG_W-1:0]  cfg_wdata
);
    import rsmf_pkg::*;

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic push;
    logic full;
    logic pop;
    logic head_valid;

    rsmf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (push),
        .cmd_full  (full),
        .cmd       (push_cmd)
    );

    rsmf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    rsmf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

/* hw/rtl/rsmf_front.sv */
// ----------------------------------------------------------------------------
// rsmf_front
// Accepts readings, gates them on range, counts the batch and tags the last.
// ----------------------------------------------------------------------------
module rsmf_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  rsmf_pkg::in_item_t      in_data,
    input  logic                    cfg_we,
    input  logic [rsmf_pkg::CFG_W-1:0] cfg_wdata,
    output logic                    cmd_valid,
    input  logic                    cmd_full,
    output rsmf_pkg::cmd_t          cmd
);
    import rsmf_pkg::*;

    logic [CFG_W-1:0]   sample_count_reg;
    logic [COUNT_W-1:0] seen_reg;
    logic [COUNT_W-1:0] seen_next;
    logic [COUNT_W-1:0] batch_size;
    logic               accept;
    logic               in_range;

    assign in_stall  = cmd_full;
    assign accept    = in_valid && !cmd_full;
    assign cmd_valid = accept;

    always_comb
    begin
        if (sample_count_reg == '0)
            batch_size = COUNT_W'(1);
        else if (COUNT_W'(sample_count_reg) > COUNT_W'(MAX_SAMPLES))
            batch_size = COUNT_W'(MAX_SAMPLES);
        else
            batch_size = COUNT_W'(sample_count_reg);
    end

    // Error codes at 8190 and above already fall outside the window
    assign in_range  = (in_data.raw_range >= RANGE_MIN_MM)
                    && (in_data.raw_range <= RANGE_MAX_MM);
    assign seen_next = seen_reg + COUNT_W'(1);

    always_comb
    begin
        cmd.value = in_data.raw_range[MM_W-1:0];
        cmd.last  = (seen_next >= batch_size);
        if (in_data.abort)
            cmd.kind = CMD_ABORT;
        else if (in_range)
            cmd.kind = CMD_KEEP;
        else
            cmd.kind = CMD_DROP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= SAMPLE_COUNT_RESET;
            seen_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
                sample_count_reg <= cfg_wdata;
            if (accept)
            begin
                if (in_data.abort || cmd.last)
                    seen_reg <= '0;
                else
                    seen_reg <= seen_next;
            end
        end
    end

endmodule

/* hw/rtl/rsmf_queue.sv */
// ----------------------------------------------------------------------------
// rsmf_queue
// Short command queue between the front end and the sorter.
// ----------------------------------------------------------------------------
module rsmf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rsmf_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output rsmf_pkg::cmd_t head_cmd
);
    import rsmf_pkg::*;

    cmd_t              slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slots[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule

/* hw/rtl/rsmf_back.sv */
// ----------------------------------------------------------------------------
// rsmf_back
// Insertion sorter over a sorted reading store; reads out the upper median.
// ----------------------------------------------------------------------------
module rsmf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  rsmf_pkg::cmd_t      head_cmd,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output rsmf_pkg::out_item_t out_data
);
    import rsmf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_PUT,
        S_MED,
        S_FETCH,
        S_EMIT
    } state_t;

    state_t             state_reg;
    logic [COUNT_W-1:0] kept_reg;
    logic [ADDR_W-1:0]  idx_reg;
    logic [MM_W-1:0]    val_reg;
    logic               last_reg;
    out_item_t          res_reg;
    out_item_t          out_reg;
    logic               out_valid_reg;

    logic [MM_W-1:0]    mem [MAX_SAMPLES];
    logic [MM_W-1:0]    rdata;
    logic [ADDR_W-1:0]  rd_addr;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [MM_W-1:0]    mem_wdata;
    logic               shift;
    logic               out_free;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign shift     = (rdata > val_reg);

    always_comb
    begin
        pop       = 1'b0;
        rd_addr   = '0;
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = val_reg;
        case (state_reg)
            S_IDLE:
            begin
                pop = head_valid;
                if (kept_reg != '0)
                    rd_addr = ADDR_W'(kept_reg - COUNT_W'(1));
            end
            S_CMP:
            begin
                // Move the larger entry up one place and fetch the next one down
                if (shift)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = rdata;
                    rd_addr   = idx_reg - ADDR_W'(2);
                end
            end
            S_PUT:
                mem_we = 1'b1;
            S_MED:
                rd_addr = ADDR_W'(kept_reg >> 1);
            default:
                rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kept_reg      <= '0;
            idx_reg       <= '0;
            val_reg       <= '0;
            last_reg      <= 1'b0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_EMIT)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (head_valid)
                    begin
                        val_reg  <= head_cmd.value;
                        last_reg <= head_cmd.last;
                        case (head_cmd.kind)
                            CMD_ABORT:
                            begin
                                res_reg   <= '0;
                                state_reg <= S_EMIT;
                            end
                            CMD_KEEP:
                            begin
                                idx_reg <= ADDR_W'(kept_reg);
                                if (kept_reg == '0)
                                    state_reg <= S_PUT;
                                else
                                    state_reg <= S_CMP;
                            end
                            default:
                            begin
                                if (head_cmd.last)
                                begin
                                    if (kept_reg == '0)
                                    begin
                                        res_reg   <= '0;
                                        state_reg <= S_EMIT;
                                    end
                                    else
                                        state_reg <= S_MED;
                                end
                            end
                        endcase
                    end
                end
                S_CMP:
                begin
                    if (shift)
                    begin
                        idx_reg <= idx_reg - ADDR_W'(1);
                        if (idx_reg == ADDR_W'(1))
                            state_reg <= S_PUT;
                    end
                    else
                        state_reg <= S_PUT;
                end
                S_PUT:
                begin
                    kept_reg <= kept_reg + COUNT_W'(1);
                    if (last_reg)
                        state_reg <= S_MED;
                    else
                        state_reg <= S_IDLE;
                end
                S_MED:
                    state_reg <= S_FETCH;
                S_FETCH:
                begin
                    res_reg.median_mm <= rdata;
                    res_reg.found     <= 1'b1;
                    state_reg         <= S_EMIT;
                end
                S_EMIT:
                begin
                    // Hold the result until the output register is free
                    if (out_free)
                    begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        kept_reg      <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* dv/range_sample_median_filter_tb.sv */
// ----------------------------------------------------------------------------
// range_sample_median_filter_tb
// Self-checking bench for the batch median filter. A predictor keeps its
// own sorted store of gated readings and batch counters, queues the median
// due at each batch end or abort, and compares it with every item taken
// from the output. Stimulus runs through boundary readings first, then
// random batches under several batch sizes, with bursty idling on both sides in most phases.
// ----------------------------------------------------------------------------
module range_sample_median_filter_tb;

    import rsmf_pkg::*;

    localparam logic [RAW_W-1:0] ERROR_CODE_MM = RAW_W'(8190);
    localparam int               DRAIN_CYCLES  = 200;
    localparam int               PHASES        = 10;
    localparam int               PHASE_ITEMS   = 65;

    class median_board;
        logic [CFG_W-1:0] batch_reg;
        logic [MM_W-1:0]  kept_mm[$];
        int unsigned      seen;
        out_item_t        medians_due[$];
        int unsigned      misses;

        function new();
            batch_reg = SAMPLE_COUNT_RESET;
            seen      = 0;
            misses    = 0;
        endfunction

        function void set_batch(logic [CFG_W-1:0] v);
            batch_reg = v;
        endfunction

        function int unsigned due();
            return medians_due.size();
        endfunction

        function void close_batch(logic [MM_W-1:0] mm, logic hit);
            out_item_t r;
            r.median_mm = mm;
            r.found     = hit;
            medians_due.insert(medians_due.size(), r);
            kept_mm.delete();
            seen = 0;
        endfunction

        function void note_reading(in_item_t it);
            int unsigned size;
            int          pos;
            if (it.abort)
            begin
                close_batch('0, 1'b0);
                return;
            end
            // gate on range, then insert keeping the store ascending
            if (it.raw_range >= RANGE_MIN_MM && it.raw_range <= RANGE_MAX_MM
                && it.raw_range < ERROR_CODE_MM && kept_mm.size() < MAX_SAMPLES)
            begin
                pos = kept_mm.size();
                while (pos > 0 && kept_mm[pos-1] > it.raw_range[MM_W-1:0])
                    pos--;
                kept_mm.insert(pos, it.raw_range[MM_W-1:0]);
            end
            seen++;
            size = (batch_reg == 0) ? 1 :
                   ((batch_reg > MAX_SAMPLES) ? MAX_SAMPLES : batch_reg);
            if (seen < size)
                return;
            if (kept_mm.size() == 0)
                close_batch('0, 1'b0);
            else
                close_batch(kept_mm[kept_mm.size() / 2], 1'b1);
        endfunction

        function void check_median(out_item_t got);
            out_item_t want;
            if (medians_due.size() == 0)
            begin
                if (misses < 10)
                    $display("unexpected median: mm=%0d found=%0b",
                             got.median_mm, got.found);
                misses++;
                return;
            end
            want = medians_due.pop_front();
            if (got.median_mm !== want.median_mm || got.found !== want.found)
            begin
                if (misses < 10)
                    $display("median mismatch: expected mm=%0d found=%0b, got mm=%0d found=%0b",
                             want.median_mm, want.found, got.median_mm, got.found);
                misses++;
            end
        endfunction

        function void wrap_up();
            if (medians_due.size() != 0)
            begin
                if (misses < 10)
                    $display("%0d medians never arrived", medians_due.size());
                misses++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    in_item_t         in_data;
    logic             out_valid;
    logic             out_stall;
    out_item_t        out_data;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    median_board      medians = new();
    bit               gaps_on;
    logic [RAW_W-1:0] last_mm;

    range_sample_median_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            medians.check_median(out_data);
    end

    // output side: stall in random bursts
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic in_item_t reading(int unsigned mm, bit ab);
        in_item_t it;
        it.raw_range = RAW_W'(mm);
        it.abort     = ab;
        return it;
    endfunction

    function automatic in_item_t random_reading(bit falling, int unsigned n);
        in_item_t    it;
        int unsigned pick;
        it.abort = 1'b0;
        pick     = $urandom_range(0, 99);
        if (pick < 3)
        begin
            it.abort     = 1'b1;
            it.raw_range = RAW_W'($urandom);
        end
        else if (falling)
            it.raw_range = RAW_W'(1200 - 35 * (n % 32));
        else if (pick < 73)
            it.raw_range = RAW_W'($urandom_range(10, 1200));
        else if (pick < 83)
        begin
            case ($urandom_range(0, 5))
                0:       it.raw_range = RANGE_MIN_MM - 1;
                1:       it.raw_range = RANGE_MIN_MM;
                2:       it.raw_range = RANGE_MAX_MM;
                3:       it.raw_range = RANGE_MAX_MM + 1;
                4:       it.raw_range = ERROR_CODE_MM - 1;
                default: it.raw_range = ERROR_CODE_MM;
            endcase
        end
        else if (pick < 93)
            it.raw_range = RAW_W'($urandom_range(0, 65535));
        else
            it.raw_range = last_mm;
        if (!it.abort)
            last_mm = it.raw_range;
        return it;
    endfunction

    // hold the item until it is taken; valid stays high for a following item
    task automatic push_reading(in_item_t it);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        medians.note_reading(it);
    endtask

    // drop valid, wait for every median due, then let queued readings drain
    task automatic settle();
        in_valid <= 1'b0;
        while (medians.due() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_batch(logic [CFG_W-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        medians.set_batch(v);
    endtask

    initial
    begin
        logic [CFG_W-1:0] cfg;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        last_mm    = RANGE_MIN_MM;
        gaps_on    = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        gaps_on = 1'b1;

        // one reading per batch: every gate boundary and an abort
        write_batch(CFG_W'(1));
        push_reading(reading(0, 1'b0));
        push_reading(reading(RANGE_MIN_MM - 1, 1'b0));
        push_reading(reading(RANGE_MIN_MM, 1'b0));
        push_reading(reading(RANGE_MAX_MM, 1'b0));
        push_reading(reading(RANGE_MAX_MM + 1, 1'b0));
        push_reading(reading(ERROR_CODE_MM, 1'b0));
        push_reading(reading(16'hFFFF, 1'b0));
        push_reading(reading(16'hFFFF, 1'b1));

        // batch size zero behaves as one
        write_batch(CFG_W'(0));
        push_reading(reading(500, 1'b0));

        // odd count with a rejected reading, then upper median of two
        write_batch(CFG_W'(4));
        push_reading(reading(300, 1'b0));
        push_reading(reading(100, 1'b0));
        push_reading(reading(RANGE_MIN_MM - 1, 1'b0));
        push_reading(reading(1200, 1'b0));
        write_batch(CFG_W'(2));
        push_reading(reading(40, 1'b0));
        push_reading(reading(20, 1'b0));

        // abort part way through, then a clean batch
        write_batch(CFG_W'(4));
        push_reading(reading(50, 1'b0));
        push_reading(reading(60, 1'b0));
        push_reading(reading(0, 1'b1));
        push_reading(reading(70, 1'b0));
        push_reading(reading(80, 1'b0));
        push_reading(reading(90, 1'b0));
        push_reading(reading(100, 1'b0));

        // shrink the batch below what has already been seen
        write_batch(CFG_W'(8));
        push_reading(reading(700, 1'b0));
        push_reading(reading(600, 1'b0));
        push_reading(reading(500, 1'b0));
        write_batch(CFG_W'(2));
        push_reading(reading(400, 1'b0));

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       cfg = CFG_W'(MAX_SAMPLES);
                1:       cfg = '1;
                2:       cfg = '0;
                default:
                begin
                    case ($urandom_range(0, 3))
                        0:       cfg = CFG_W'($urandom_range(0, 63));
                        1:       cfg = CFG_W'($urandom_range(11, 32));
                        default: cfg = CFG_W'($urandom_range(2, 10));
                    endcase
                end
            endcase
            write_batch(cfg);
            gaps_on = (p != 3) && (p < PHASES - 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_reading(random_reading(p == 0, n));
        end

        settle();
        medians.wrap_up();
        if (medians.misses == 0)
            $display("[range_sample_median_filter] OK");
        else
            $display("[range_sample_median_filter] ERROR");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("[range_sample_median_filter] ERROR");
        $finish;
    end

endmodule
